// File: rtl/urtm_pkg.sv
// Shared constants and types for the ultrasonic range trimmed-mean filter.
`default_nettype none

package urtm_pkg;

   localparam int SAMPLES_DEF   = 5;
   localparam int ECHO_W        = 16;
   localparam int DIST_W        = 10;
   localparam int CSR_DATA_W    = 16;
   localparam int DVD_W         = 16;
   localparam int RCP_W         = 27;
   localparam int RCP_SHIFT     = 26;
   localparam int CONV_MUL      = 17;
   localparam int CM_DIVISOR    = 1000;
   localparam int TIMEOUT_RESET = 30000;
   localparam int RANGE_RESET   = 500;

   typedef enum logic [0:0] {
      CSR_TIMEOUT   = 1'b0,
      CSR_MAX_RANGE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SCAN,
      ST_TRIM,
      ST_MEAN,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// File: rtl/ultrasonic_range_trimmed_mean.sv
// Top level of the ultrasonic range trimmed-mean filter.
// An input beat flagged as timed out or over the timeout register is dropped.
// Other beats are multiplied by 17 and divided by 1000 on the shared reciprocal multiplier.
// The beat that fills the window adds a scan of all SAMPLES entries, then the trimmed mean.
// One beat is worked at a time; the result register lets the next beat in while it waits.
// Synchronous reset empties the window, drops any result and restores register defaults.
`default_nettype none

module ultrasonic_range_trimmed_mean #(
   parameter int SAMPLES = urtm_pkg::SAMPLES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [urtm_pkg::ECHO_W-1:0]     req_echo_us,
   input  wire logic                            req_timed_out,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [urtm_pkg::DIST_W-1:0]          rsp_distance_cm,
   input  wire logic                            csr_we,
   input  wire urtm_pkg::csr_index_type         csr_index,
   input  wire logic [urtm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import urtm_pkg::*;

   localparam int IDX_W = $clog2(SAMPLES);
   localparam int SUM_W = $clog2(SAMPLES * ((1 << DIST_W) - 1) + 1);
   localparam int QUO_W = DVD_W + RCP_W - RCP_SHIFT;
   localparam logic [RCP_W-1:0] MEAN_RECIP =
      RCP_W'(((64'd1 << RCP_SHIFT) + 64'(SAMPLES - 3)) / 64'(SAMPLES - 2));
   localparam logic [RCP_W-1:0] CONV_RECIP =
      RCP_W'(((64'(CONV_MUL) << RCP_SHIFT) + 64'(CM_DIVISOR - 1)) / 64'(CM_DIVISOR));

   state_type            state_ff, state_in;
   logic [ECHO_W-1:0]    timeout_ff;
   logic [DIST_W-1:0]    range_ff;
   logic [DIST_W-1:0]    store_ff [SAMPLES];
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [DIST_W-1:0]    lo_ff, lo_in;
   logic [DIST_W-1:0]    hi_ff, hi_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]    rsp_dist_ff, rsp_dist_in;
   logic                 store_we;
   logic [DIST_W-1:0]    cur;
   logic                 div_start;
   logic [DVD_W-1:0]     div_dividend;
   logic [RCP_W-1:0]     div_recip;
   logic                 div_done;
   logic [QUO_W-1:0]     div_quotient;
   logic                 accept;

   urtm_div #(
      .DVD_W    (DVD_W),
      .RCP_W    (RCP_W),
      .RCP_SHIFT(RCP_SHIFT)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .recip   (div_recip),
      .done    (div_done),
      .quotient(div_quotient)
   );

   assign accept = req_valid && !req_stall;
   assign cur    = store_ff[scan_ff];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      scan_in      = scan_ff;
      sum_in       = sum_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_dist_in  = rsp_dist_ff;
      store_we     = 1'b0;
      div_start    = 1'b0;
      div_dividend = DVD_W'(req_echo_us);
      div_recip    = CONV_RECIP;
      req_stall    = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !req_timed_out && !(req_echo_us > timeout_ff)) begin
               div_start = 1'b1;
               state_in  = ST_CONV;
            end
         end
         ST_CONV: begin
            if (div_done) begin
               if (div_quotient == '0 || div_quotient >= QUO_W'(range_ff)) begin
                  state_in = ST_IDLE;
               end else begin
                  store_we = 1'b1;
                  if (cnt_ff == IDX_W'(SAMPLES - 1)) begin
                     cnt_in   = '0;
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end else begin
                     cnt_in   = cnt_ff + 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (scan_ff == '0) begin
               sum_in = SUM_W'(cur);
               lo_in  = cur;
               hi_in  = cur;
            end else begin
               sum_in = sum_ff + SUM_W'(cur);
               lo_in  = (cur < lo_ff) ? cur : lo_ff;
               hi_in  = (cur > hi_ff) ? cur : hi_ff;
            end
            if (scan_ff == IDX_W'(SAMPLES - 1)) begin
               state_in = ST_TRIM;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_TRIM: begin
            div_start    = 1'b1;
            div_dividend = DVD_W'(sum_ff - SUM_W'(lo_ff) - SUM_W'(hi_ff));
            div_recip    = MEAN_RECIP;
            state_in     = ST_MEAN;
         end
         ST_MEAN: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = div_quotient[DIST_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_ff      <= sum_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      rsp_dist_ff <= rsp_dist_in;
      if (store_we) begin
         store_ff[cnt_ff] <= div_quotient[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= ECHO_W'(TIMEOUT_RESET);
         range_ff   <= DIST_W'(RANGE_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIMEOUT:   timeout_ff <= csr_wdata[ECHO_W-1:0];
            CSR_MAX_RANGE: range_ff   <= csr_wdata[DIST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance_cm = rsp_dist_ff;

endmodule

`default_nettype wire

// File: rtl/urtm_div.sv
// Shared divide-by-constant unit: a reciprocal multiply with a registered product.
`default_nettype none

module urtm_div #(
   parameter int DVD_W     = urtm_pkg::DVD_W,
   parameter int RCP_W     = urtm_pkg::RCP_W,
   parameter int RCP_SHIFT = urtm_pkg::RCP_SHIFT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [DVD_W-1:0]              dividend,
   input  wire logic [RCP_W-1:0]              recip,
   output logic                               done,
   output logic [DVD_W+RCP_W-RCP_SHIFT-1:0]   quotient
);
   import urtm_pkg::*;

   localparam int PRD_W = DVD_W + RCP_W;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [RCP_W-1:0] rcp_ff, rcp_in;
   logic [PRD_W-1:0] prod_ff, prod_in;

   always_comb begin
      busy_in = start;
      done_in = busy_ff;
      dvd_in  = start ? dividend : dvd_ff;
      rcp_in  = start ? recip : rcp_ff;
      prod_in = busy_ff ? ({{RCP_W{1'b0}}, dvd_ff} * {{DVD_W{1'b0}}, rcp_ff}) : prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvd_ff  <= dvd_in;
      rcp_ff  <= rcp_in;
      prod_ff <= prod_in;
   end

   assign done     = done_ff;
   assign quotient = prod_ff[PRD_W-1:RCP_SHIFT];

endmodule

`default_nettype wire
